// File: hdl/framebuffer_pixel_writer_defines.svh
// assertion macros for the framebuffer pixel writer
// used by the top level only, no other dependencies
`ifndef FRAMEBUFFER_PIXEL_WRITER_DEFINES_SVH
`define FRAMEBUFFER_PIXEL_WRITER_DEFINES_SVH

// same-cycle implication under reset
`define FBPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define FBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/fbpw_pkg.sv
// shared constants for the framebuffer pixel writer
// no dependencies
package fbpw_pkg;

    localparam int PROD_W     = 21;
    localparam int LIN_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int STATE_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;

    localparam logic [2:0] FMT_MONO    = 3'd0;
    localparam logic [2:0] FMT_GRAY_LO = 3'd1;
    localparam logic [2:0] FMT_GRAY_HI = 3'd2;
    localparam logic [2:0] FMT_BYTE    = 3'd3;
    localparam logic [2:0] FMT_RGB16   = 3'd4;
    localparam logic [2:0] FMT_RGB666  = 3'd5;
    localparam logic [2:0] FMT_RGB888  = 3'd6;

    localparam logic [23:0] MONO_CLEAR  = 24'd0;
    localparam logic [23:0] MONO_TOGGLE = 24'd2;

    localparam logic [2:0]  FORMAT_RESET = 3'd0;
    localparam logic [10:0] WIDTH_RESET  = 11'd128;

    typedef logic [STATE_W-1:0] state_t;

endpackage

// File: hdl/fbpw_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module fbpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/framebuffer_pixel_writer.sv
// framebuffer pixel writer top level: plot and byte read over one frame ram
// depends on fbpw_pkg, fbpw_ram and framebuffer_pixel_writer_defines.svh
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  command  | start, busy               | operation, pixel_x, pixel_y, pixel_color,
//           |                           | byte_address
//  result   | result_valid (one cycle)  | read_byte
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// read: the address is registered on accept, read from the ram in S_RD and returned in S_RESP
// plot: address math in S_MUL, S_ADDR and S_CHECK, then a mono/gray read-modify-write in S_RD
//   and S_MOD or S_WRITE for each byte written, then back to idle; a dropped pixel returns to
//   idle from S_CHECK; the single ram write port makes the bytes go out in turn
// after reset the frame is cleared one byte a cycle, all FRAME_BYTES bytes, with busy high
// results cannot be stalled; config is taken any cycle, cfg_ready is always high
`include "framebuffer_pixel_writer_defines.svh"

module framebuffer_pixel_writer #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [9:0]                     pixel_x,
    input  logic [9:0]                     pixel_y,
    input  logic [23:0]                    pixel_color,
    input  logic [15:0]                    byte_address,
    output logic                           result_valid,
    output logic [7:0]                     read_byte,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LW = fbpw_pkg::LIN_W;
    localparam int PW = fbpw_pkg::PROD_W;
    localparam logic [LW-1:0] FRAME_END = LW'(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    localparam fbpw_pkg::state_t S_CLEAR = 4'd0;
    localparam fbpw_pkg::state_t S_IDLE  = 4'd1;
    localparam fbpw_pkg::state_t S_MUL   = 4'd2;
    localparam fbpw_pkg::state_t S_ADDR  = 4'd3;
    localparam fbpw_pkg::state_t S_CHECK = 4'd4;
    localparam fbpw_pkg::state_t S_WRITE = 4'd5;
    localparam fbpw_pkg::state_t S_RD    = 4'd6;
    localparam fbpw_pkg::state_t S_MOD   = 4'd7;
    localparam fbpw_pkg::state_t S_RESP  = 4'd8;

    fbpw_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [2:0]       fmt_reg, fmt_next;
    logic [10:0]      width_reg, width_next;

    logic             op_reg, op_next;
    logic [9:0]       x_reg, x_next;
    logic [9:0]       y_reg, y_next;
    logic [23:0]      color_reg, color_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [1:0]       left_reg, left_next;
    logic [23:0]      seq_reg, seq_next;
    logic             rd_ok_reg, rd_ok_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    logic [9:0]       y_mul;
    logic [LW-1:0]    lin_pix;
    logic [LW-1:0]    lin_gray;
    logic             fits;
    logic [7:0]       mono_mask;
    logic [7:0]       mod_byte;
    logic             gray_high;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = (state_reg == S_RESP);
    assign read_byte    = rd_ok_reg ? ram_rdata : 8'h00;

    assign y_mul     = (fmt_reg == fbpw_pkg::FMT_MONO) ? {3'b000, y_reg[9:3]} : y_reg;
    assign prod_next = {{(PW-10){1'b0}}, y_mul} * {{(PW-11){1'b0}}, width_reg};
    assign lin_pix   = LW'(prod_reg) + LW'(x_reg);
    assign lin_gray  = LW'(prod_reg[PW-1:1]) + LW'(x_reg[9:1]);
    assign fits      = (cur_reg + LW'(left_reg)) <= FRAME_END;
    assign mono_mask = 8'h01 << y_reg[2:0];
    assign gray_high = x_reg[0] == (fmt_reg == fbpw_pkg::FMT_GRAY_LO);

    always_comb
    begin
        if (fmt_reg == fbpw_pkg::FMT_MONO)
        begin
            if (color_reg == fbpw_pkg::MONO_TOGGLE)
            begin
                mod_byte = ram_rdata ^ mono_mask;
            end
            else if (color_reg == fbpw_pkg::MONO_CLEAR)
            begin
                mod_byte = ram_rdata & ~mono_mask;
            end
            else
            begin
                mod_byte = ram_rdata | mono_mask;
            end
        end
        else if (gray_high)
        begin
            mod_byte = {color_reg[3:0], ram_rdata[3:0]};
        end
        else
        begin
            mod_byte = {ram_rdata[7:4], color_reg[3:0]};
        end
    end

    always_comb
    begin
        fmt_next   = fmt_reg;
        width_next = width_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fbpw_pkg::CFG_PIXEL_FORMAT)
            begin
                fmt_next = cfg_data[2:0];
            end
            else if (cfg_index == fbpw_pkg::CFG_LINE_WIDTH)
            begin
                width_next = cfg_data[10:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        seq_next   = seq_reg;
        rd_ok_next = rd_ok_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg[AW-1:0];
        ram_wdata  = seq_reg[23:16];
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'h00;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    x_next     = pixel_x;
                    y_next     = pixel_y;
                    color_next = pixel_color;
                    cur_next   = LW'(byte_address);
                    rd_ok_next = LW'(byte_address) < FRAME_END;
                    state_next = operation ? S_RD : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                state_next = S_CHECK;
                unique case (fmt_reg)
                    fbpw_pkg::FMT_MONO:
                    begin
                        cur_next  = lin_pix;
                        left_next = 2'd1;
                    end
                    fbpw_pkg::FMT_GRAY_LO, fbpw_pkg::FMT_GRAY_HI:
                    begin
                        cur_next  = lin_gray;
                        left_next = 2'd1;
                    end
                    fbpw_pkg::FMT_BYTE:
                    begin
                        cur_next  = lin_pix;
                        left_next = 2'd1;
                        seq_next  = {color_reg[7:0], 16'h0000};
                    end
                    fbpw_pkg::FMT_RGB16:
                    begin
                        cur_next  = lin_pix << 1;
                        left_next = 2'd2;
                        seq_next  = {color_reg[15:0], 8'h00};
                    end
                    fbpw_pkg::FMT_RGB666:
                    begin
                        cur_next  = lin_pix + (lin_pix << 1);
                        left_next = 2'd3;
                        seq_next  = {2'b00, color_reg[17:12], 2'b00, color_reg[11:6],
                                     2'b00, color_reg[5:0]};
                    end
                    fbpw_pkg::FMT_RGB888:
                    begin
                        cur_next  = lin_pix + (lin_pix << 1);
                        left_next = 2'd3;
                        seq_next  = color_reg;
                    end
                    default:
                    begin
                        left_next = 2'd0;
                    end
                endcase
            end
            S_CHECK:
            begin
                if ((left_reg == 2'd0) || !fits)
                begin
                    state_next = S_IDLE;
                end
                else if ((fmt_reg == fbpw_pkg::FMT_MONO) ||
                         (fmt_reg == fbpw_pkg::FMT_GRAY_LO) ||
                         (fmt_reg == fbpw_pkg::FMT_GRAY_HI))
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                cur_next  = cur_reg + LW'(1);
                left_next = left_reg - 2'd1;
                seq_next  = {seq_reg[15:0], 8'h00};
                if (left_reg == 2'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = op_reg ? S_RESP : S_MOD;
            end
            S_MOD:
            begin
                ram_we     = 1'b1;
                ram_wdata  = mod_byte;
                state_next = S_IDLE;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            fmt_reg   <= fbpw_pkg::FORMAT_RESET;
            width_reg <= fbpw_pkg::WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fmt_reg   <= fmt_next;
            width_reg <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        prod_reg  <= prod_next;
        cur_reg   <= cur_next;
        left_reg  <= left_next;
        seq_reg   <= seq_next;
        rd_ok_reg <= rd_ok_next;
    end

    fbpw_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    `FBPW_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid,
        "result strobe longer than one cycle")
    `FBPW_ASSERT_NEXT(a_read_latency, clk, rst_n, start && !busy && operation,
        ##1 result_valid, "read word not returned two cycles after accept")
    `FBPW_ASSERT_NOW(a_write_in_frame, clk, rst_n,
        (state_reg == S_WRITE) || (state_reg == S_MOD), cur_reg < FRAME_END,
        "pixel write beyond frame")

endmodule

// File: sim/framebuffer_pixel_writer_tb.sv
// self-checking testbench for framebuffer_pixel_writer: directed table, then random phases
// keeps its own copy of the frame and the registers to predict the read words that the table does not fix
// depends on fbpw_pkg and the framebuffer_pixel_writer rtl
module framebuffer_pixel_writer_tb;

    localparam int FRAME_SIZE      = 65536;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 200;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int QUIET_PHASES    = 3;
    localparam int RECENT_DEPTH    = 16;

    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0]                     FMT_UNUSED  = 3'd7;
    localparam logic [fbpw_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [fbpw_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic { ROW_CFG, ROW_CMD } row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic [fbpw_pkg::CFG_IDX_W-1:0]      idx;
        logic [fbpw_pkg::CFG_DATA_W-1:0]     data;
        logic                                op;
        logic [9:0]                          x;
        logic [9:0]                          y;
        logic [23:0]                         color;
        logic [15:0]                         addr;
        bit                                  fixed;
        logic [7:0]                          want;
    } stim_row_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            start        = 1'b0;
    logic                            busy;
    logic                            operation    = OP_PLOT;
    logic [9:0]                      pixel_x      = '0;
    logic [9:0]                      pixel_y      = '0;
    logic [23:0]                     pixel_color  = '0;
    logic [15:0]                     byte_address = '0;
    logic                            result_valid;
    logic [7:0]                      read_byte;
    logic                            cfg_valid    = 1'b0;
    logic                            cfg_ready;
    logic [fbpw_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    bit [7:0]          frame_copy [FRAME_SIZE];
    logic [2:0]        cur_format = fbpw_pkg::FORMAT_RESET;
    logic [10:0]       cur_width  = fbpw_pkg::WIDTH_RESET;
    logic [7:0]        pending_bytes [$];
    longint unsigned   recent_addr [$];
    stim_row_t         directed_rows [$];
    int                errors      = 0;
    int                cycle_count = 0;

    framebuffer_pixel_writer #(
        .FRAME_BYTES(FRAME_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .pixel_color(pixel_color),
        .byte_address(byte_address),
        .result_valid(result_valid),
        .read_byte(read_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned first_byte(input logic [2:0] fmt, input logic [10:0] w,
                                                   input logic [9:0] x, input logic [9:0] y);
        longint unsigned lw;
        longint unsigned lx;
        longint unsigned ly;
        longint unsigned p;
        lw = w;
        lx = x;
        ly = y;
        p  = ly * lw + lx;
        case (fmt)
            fbpw_pkg::FMT_MONO:
                return (ly >> 3) * lw + lx;
            fbpw_pkg::FMT_GRAY_LO, fbpw_pkg::FMT_GRAY_HI:
                return ((ly * lw) >> 1) + (lx >> 1);
            fbpw_pkg::FMT_RGB16:
                return p * 64'd2;
            fbpw_pkg::FMT_RGB666, fbpw_pkg::FMT_RGB888:
                return p * 64'd3;
            default:
                return p;
        endcase
    endfunction

    function automatic int unsigned byte_count(input logic [2:0] fmt);
        case (fmt)
            fbpw_pkg::FMT_MONO, fbpw_pkg::FMT_GRAY_LO, fbpw_pkg::FMT_GRAY_HI,
            fbpw_pkg::FMT_BYTE:
                return 1;
            fbpw_pkg::FMT_RGB16:
                return 2;
            fbpw_pkg::FMT_RGB666, fbpw_pkg::FMT_RGB888:
                return 3;
            default:
                return 0;
        endcase
    endfunction

    function automatic bit lands(input logic [2:0] fmt, input logic [10:0] w,
                                 input logic [9:0] x, input logic [9:0] y);
        int unsigned n;
        n = byte_count(fmt);
        return n != 0 && first_byte(fmt, w, x, y) + n <= FRAME_SIZE;
    endfunction

    function automatic void plot_pixel(input logic [9:0] x, input logic [9:0] y,
                                       input logic [23:0] color);
        longint unsigned a;
        logic [7:0]      mask;
        logic [7:0]      b;
        if (!lands(cur_format, cur_width, x, y))
            return;
        a = first_byte(cur_format, cur_width, x, y);
        case (cur_format)
            fbpw_pkg::FMT_MONO:
            begin
                mask = 8'h01 << y[2:0];
                if (color == fbpw_pkg::MONO_TOGGLE)
                    frame_copy[a] = frame_copy[a] ^ mask;
                else if (color == fbpw_pkg::MONO_CLEAR)
                    frame_copy[a] = frame_copy[a] & ~mask;
                else
                    frame_copy[a] = frame_copy[a] | mask;
            end
            fbpw_pkg::FMT_GRAY_LO, fbpw_pkg::FMT_GRAY_HI:
            begin
                b = frame_copy[a];
                if (x[0] == (cur_format == fbpw_pkg::FMT_GRAY_LO))
                    b = {color[3:0], b[3:0]};
                else
                    b = {b[7:4], color[3:0]};
                frame_copy[a] = b;
            end
            fbpw_pkg::FMT_BYTE:
                frame_copy[a] = color[7:0];
            fbpw_pkg::FMT_RGB16:
            begin
                frame_copy[a]     = color[15:8];
                frame_copy[a + 1] = color[7:0];
            end
            fbpw_pkg::FMT_RGB666:
            begin
                frame_copy[a]     = {2'b00, color[17:12]};
                frame_copy[a + 1] = {2'b00, color[11:6]};
                frame_copy[a + 2] = {2'b00, color[5:0]};
            end
            fbpw_pkg::FMT_RGB888:
            begin
                frame_copy[a]     = color[23:16];
                frame_copy[a + 1] = color[15:8];
                frame_copy[a + 2] = color[7:0];
            end
            default:
                ;
        endcase
    endfunction

    function automatic stim_row_t cfg_row(input logic [fbpw_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [fbpw_pkg::CFG_DATA_W-1:0] data);
        stim_row_t r;
        r       = '{kind: ROW_CFG, default: '0};
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic stim_row_t plot_row(input logic [9:0] x, input logic [9:0] y,
                                           input logic [23:0] color);
        stim_row_t r;
        r       = '{kind: ROW_CMD, default: '0};
        r.kind  = ROW_CMD;
        r.op    = OP_PLOT;
        r.x     = x;
        r.y     = y;
        r.color = color;
        return r;
    endfunction

    function automatic stim_row_t read_row(input logic [15:0] addr, input bit fixed,
                                           input logic [7:0] want);
        stim_row_t r;
        r       = '{kind: ROW_CMD, default: '0};
        r.kind  = ROW_CMD;
        r.op    = OP_READ;
        r.addr  = addr;
        r.fixed = fixed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [10:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2;
            3:       return 11'd7;
            4:       return 11'd128;
            5:       return 11'd320;
            6:       return 11'd1023;
            7:       return 11'd1024;
            8:       return 11'd2047;
            default: return 11'($urandom_range(1, 2047));
        endcase
    endfunction

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s, expected %02h, got %02h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_bytes.size() == 0)
                report("unexpected read word", 8'h00, read_byte);
            else if (pending_bytes[0] !== read_byte)
            begin
                report("read_byte", pending_bytes[0], read_byte);
                void'(pending_bytes.pop_front());
            end
            else
                void'(pending_bytes.pop_front());
        end
    end

    task automatic send_item(input logic op, input logic [9:0] x, input logic [9:0] y,
                             input logic [23:0] color, input logic [15:0] addr,
                             input bit fixed, input logic [7:0] want);
        @(negedge clk);
        start        <= 1'b1;
        operation    <= op;
        pixel_x      <= x;
        pixel_y      <= y;
        pixel_color  <= color;
        byte_address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_PLOT)
            plot_pixel(x, y, color);
        else
            pending_bytes.push_back(fixed ? want : frame_copy[addr]);
    endtask

    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic write_reg(input logic [fbpw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbpw_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == fbpw_pkg::CFG_PIXEL_FORMAT)
            cur_format = data[2:0];
        else if (idx == fbpw_pkg::CFG_LINE_WIDTH)
            cur_width = data[10:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            errors += pending_bytes.size();
            if (errors <= 10)
                $display("mismatch: %0d read word(s) never arrived", pending_bytes.size());
            pending_bytes.delete();
        end
    endtask

    initial
    begin
        logic [9:0]      x;
        logic [9:0]      y;
        logic [23:0]     color;
        logic [15:0]     addr;
        logic            op;
        logic [2:0]      fmt;
        logic [31:0]     r;
        bit              idle_on;
        int              pick;

        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'h00));
        directed_rows.push_back(read_row(16'hffff, 1'b1, 8'h00));
        directed_rows.push_back(plot_row(10'd0, 10'd0, 24'd1));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'h01));
        directed_rows.push_back(plot_row(10'd0, 10'd7, fbpw_pkg::MONO_TOGGLE));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'h81));
        directed_rows.push_back(plot_row(10'd0, 10'd0, fbpw_pkg::MONO_CLEAR));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'h80));
        directed_rows.push_back(plot_row(10'd1023, 10'd1023, 24'hffffff));
        directed_rows.push_back(read_row(16'd17279, 1'b1, 8'h80));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_GRAY_LO}));
        directed_rows.push_back(plot_row(10'd1, 10'd0, 24'hfffffa));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'ha0));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_GRAY_HI}));
        directed_rows.push_back(plot_row(10'd1, 10'd0, 24'h000005));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'ha5));
        // last byte past the end drops the whole pixel
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_LINE_WIDTH, 11'd1024));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_RGB888}));
        directed_rows.push_back(plot_row(10'd341, 10'd21, 24'habcdef));
        directed_rows.push_back(read_row(16'hffff, 1'b1, 8'h00));
        directed_rows.push_back(plot_row(10'd340, 10'd21, 24'habcdef));
        directed_rows.push_back(read_row(16'hfffc, 1'b1, 8'hab));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT, {8'h00, FMT_UNUSED}));
        directed_rows.push_back(plot_row(10'd0, 10'd0, 24'hffffff));
        directed_rows.push_back(cfg_row(CFG_SPARE_A, 11'h7ff));
        directed_rows.push_back(cfg_row(CFG_SPARE_B, 11'h000));
        directed_rows.push_back(plot_row(10'd0, 10'd0, 24'h00003c));
        directed_rows.push_back(read_row(16'h0000, 1'b1, 8'ha5));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_LINE_WIDTH, 11'd0));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_BYTE}));
        directed_rows.push_back(plot_row(10'd5, 10'd1023, 24'h001234));
        directed_rows.push_back(read_row(16'h0005, 1'b1, 8'h34));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_LINE_WIDTH, 11'd2047));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_RGB16}));
        directed_rows.push_back(plot_row(10'd1023, 10'd15, 24'h00beef));
        directed_rows.push_back(read_row(16'd63457, 1'b0, 8'h00));
        directed_rows.push_back(cfg_row(fbpw_pkg::CFG_PIXEL_FORMAT,
                                        {8'h00, fbpw_pkg::FMT_RGB666}));
        directed_rows.push_back(plot_row(10'd0, 10'd0, 24'hfff03f));
        directed_rows.push_back(read_row(16'h0001, 1'b0, 8'h00));

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            end
            else
                send_item(directed_rows[k].op, directed_rows[k].x, directed_rows[k].y,
                          directed_rows[k].color, directed_rows[k].addr,
                          directed_rows[k].fixed, directed_rows[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            fmt = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            r = $urandom;
            write_reg(fbpw_pkg::CFG_PIXEL_FORMAT, {r[7:0], fmt});
            write_reg(fbpw_pkg::CFG_LINE_WIDTH, pick_width());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          11'($urandom));
            recent_addr.delete();
            idle_on = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 4) != 0);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 15));
                pick  = $urandom_range(0, 99);
                op    = OP_PLOT;
                x     = 10'($urandom);
                y     = 10'($urandom);
                color = 24'($urandom);
                addr  = 16'($urandom);
                if (pick < 55)
                begin
                    if (cur_format == fbpw_pkg::FMT_MONO)
                    begin
                        case ($urandom_range(0, 3))
                            0:       color = fbpw_pkg::MONO_CLEAR;
                            1:       color = fbpw_pkg::MONO_TOGGLE;
                            default: ;
                        endcase
                    end
                    for (int t = 0; t < 12 && !lands(cur_format, cur_width, x, y); t++)
                    begin
                        y = y >> 1;
                        if (t[0])
                            x = x >> 1;
                    end
                    if (lands(cur_format, cur_width, x, y))
                    begin
                        recent_addr.push_back(first_byte(cur_format, cur_width, x, y)
                            + $urandom_range(0, byte_count(cur_format) - 1));
                        if (recent_addr.size() > RECENT_DEPTH)
                            void'(recent_addr.pop_front());
                    end
                end
                else if (pick < 85)
                begin
                    op = OP_READ;
                    if (recent_addr.size() != 0 && $urandom_range(0, 4) != 0)
                        addr = 16'(recent_addr[$urandom_range(0, recent_addr.size() - 1)]);
                end
                else
                    op = 1'($urandom);
                send_item(op, x, y, color, addr, 1'b0, 8'h00);
            end
        end

        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/fbpw_pkg.sv
hdl/fbpw_ram.sv
hdl/framebuffer_pixel_writer.sv
sim/framebuffer_pixel_writer_tb.sv
